### rtl/core/wait_command_encoder_top_assert.svh
// Assertion macros for the wait command encoder.
`ifndef WAIT_COMMAND_ENCODER_TOP_ASSERT_SVH
`define WAIT_COMMAND_ENCODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on the rising clock edge, ignored while reset is low.
`define WCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("wait command encoder check failed");

// Check a property on the rising clock edge, reset cycles included.
`define WCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wait command encoder reset check failed");

`else

`define WCE_ASSERT(label, clk, rst_n, prop)
`define WCE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/core/wce_pkg.sv
// Package with opcodes, limits and sequencer states of the wait command encoder.
package wce_pkg;

    localparam int unsigned WAIT_W = 22;

    localparam logic [WAIT_W-1:0] WAIT_MAX   = 22'd4194240;
    localparam logic [WAIT_W-1:0] NTSC_FRAME = 22'd735;
    localparam logic [WAIT_W-1:0] PAL_FRAME  = 22'd882;
    localparam logic [WAIT_W-1:0] WAIT16_MAX = 22'd65535;
    localparam logic [WAIT_W-1:0] SHORT_MAX  = 22'd16;
    localparam logic [WAIT_W-1:0] PCM_SHORT  = 22'd8;

    localparam logic [7:0] OP_LONG   = 8'h96;
    localparam logic [7:0] OP_PCM1   = 8'h81;
    localparam logic [7:0] OP_NTSC   = 8'h62;
    localparam logic [7:0] OP_PAL    = 8'h63;
    localparam logic [7:0] OP_SHORT  = 8'h70;
    localparam logic [7:0] OP_WAIT16 = 8'h61;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_16   = 3'd2;
    localparam logic [2:0] LEN_32   = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

### rtl/core/wait_command_encoder_top.sv
// Wait command encoder: turns a wait length into a sequence of wait command words.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_wait_samples, i_pcm_mode
//  out     | output    | o_out_valid/i_out_stall | o_cmd_byte, o_arg_value, o_arg_len,
//          |           |                         | o_last_cmd
//
// Each item is first loaded into the remaining-wait register, then emitted as one command
// word per cycle while the output is not stalled (N words, N is 1 to 64, or 0 for a zero wait).
// The single subtract/compare unit on the remaining wait steps the sequence: it spends
// one step per emitted command.
// Reset is synchronous, active low, and clears the sequencer and the output valid.
// A stall on the output holds the current word and pauses the sequencer.
`include "wait_command_encoder_top_assert.svh"

module wait_command_encoder_top
    import wce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [WAIT_W-1:0] i_wait_samples,
    input  logic              i_pcm_mode,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_cmd_byte,
    output logic [WAIT_W-1:0] o_arg_value,
    output logic [2:0]        o_arg_len,
    output logic              o_last_cmd
);

    t_state            r_state, n_state;
    logic [WAIT_W-1:0] r_rem,   n_rem;
    logic              r_pcm,   n_pcm;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_cmd,   n_cmd;
    logic [WAIT_W-1:0] r_arg,   n_arg;
    logic [2:0]        r_len,   n_len;
    logic              r_last,  n_last;

    logic [WAIT_W-1:0] sat_wait;
    logic              in_acc;
    logic              can_load;
    logic [WAIT_W-1:0] sub_val;
    logic [WAIT_W-1:0] diff;
    logic [7:0]        step_cmd;
    logic [WAIT_W-1:0] step_arg;
    logic [2:0]        step_len;

    // Saturate the incoming wait
    assign sat_wait = (i_wait_samples > WAIT_MAX) ? WAIT_MAX : i_wait_samples;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign can_load = !r_ovalid || !i_out_stall;

    // Shared unit: pick the command for the remaining wait and subtract its share
    always_comb begin
        step_cmd = OP_WAIT16;
        step_arg = '0;
        step_len = LEN_NONE;
        sub_val  = r_rem;
        if (r_pcm && r_rem > PCM_SHORT) begin
            step_cmd = OP_LONG;
            step_arg = r_rem;
            step_len = LEN_32;
        end else if (r_pcm) begin
            step_cmd = OP_PCM1;
            sub_val  = {{(WAIT_W-1){1'b0}}, 1'b1};
        end else if (r_rem == NTSC_FRAME) begin
            step_cmd = OP_NTSC;
        end else if (r_rem == PAL_FRAME) begin
            step_cmd = OP_PAL;
        end else if (r_rem <= SHORT_MAX) begin
            step_cmd = OP_SHORT | {4'd0, 4'(r_rem - {{(WAIT_W-1){1'b0}}, 1'b1})};
        end else begin
            sub_val  = (r_rem < WAIT16_MAX) ? r_rem : WAIT16_MAX;
            step_cmd = OP_WAIT16;
            step_arg = sub_val;
            step_len = LEN_16;
        end
        diff = r_rem - sub_val;
    end

    // Sequencer: next state and output word
    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_pcm    = r_pcm;
        n_ovalid = r_ovalid && i_out_stall;
        n_cmd    = r_cmd;
        n_arg    = r_arg;
        n_len    = r_len;
        n_last   = r_last;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_rem = sat_wait;
                    n_pcm = i_pcm_mode;
                    if (sat_wait != '0) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_cmd    = step_cmd;
                    n_arg    = step_arg;
                    n_len    = step_len;
                    n_last   = (diff == '0);
                    n_rem    = diff;
                    if (diff == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_pcm  <= n_pcm;
        r_cmd  <= n_cmd;
        r_arg  <= n_arg;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd_byte  = r_cmd;
    assign o_arg_value = r_arg;
    assign o_arg_len   = r_len;
    assign o_last_cmd  = r_last;

    // Checks
    `WCE_ASSERT(a_run_has_wait, i_clk, i_rst_n, (r_state == ST_RUN) |-> (r_rem != '0))
    `WCE_ASSERT(a_idle_word_is_last, i_clk, i_rst_n,
        (r_ovalid && r_state == ST_IDLE) |-> r_last)
    `WCE_ASSERT(a_arg_only_on_arg_cmds, i_clk, i_rst_n,
        (r_ovalid && r_len != LEN_NONE) |-> (r_cmd == OP_WAIT16 || r_cmd == OP_LONG))
    `WCE_ASSERT(a_nonzero_starts_run, i_clk, i_rst_n,
        (in_acc && sat_wait != '0) |=> (r_state == ST_RUN))
    `WCE_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !r_ovalid)

endmodule

### dv/wait_command_encoder_top_tb.sv
// Self-checking testbench for the wait command encoder: random and directed waits.
`timescale 1ns / 1ps

module wait_command_encoder_top_tb
    import wce_pkg::*;
();

    typedef struct packed {
        logic [7:0]        cmd;
        logic [WAIT_W-1:0] arg;
        logic [2:0]        len;
        logic              is_last;
    } t_cmd_word;

    // Holds the command words still owed by the encoder and matches them in order.
    class cmd_ledger;
        t_cmd_word owed_cmds[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Print one line per problem and count it.
        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void add_word(input logic [7:0] cmd, input logic [WAIT_W-1:0] arg,
                               input logic [2:0] len);
            t_cmd_word w;
            w.cmd     = cmd;
            w.arg     = arg;
            w.len     = len;
            w.is_last = 1'b0;
            owed_cmds.push_back(w);
        endfunction

        // Expand one accepted wait into the command words it must produce.
        function void note_wait(input logic [WAIT_W-1:0] samples, input logic pcm);
            logic [WAIT_W-1:0] left;
            logic [WAIT_W-1:0] part;
            left = (samples > WAIT_MAX) ? WAIT_MAX : samples;
            if (left == '0) return;
            if (pcm && left > PCM_SHORT) begin
                add_word(OP_LONG, left, LEN_32);
            end else begin
                while (left != '0) begin
                    if (pcm) begin
                        add_word(OP_PCM1, '0, LEN_NONE);
                        left = left - WAIT_W'(1);
                    end else if (left == NTSC_FRAME) begin
                        add_word(OP_NTSC, '0, LEN_NONE);
                        left = '0;
                    end else if (left == PAL_FRAME) begin
                        add_word(OP_PAL, '0, LEN_NONE);
                        left = '0;
                    end else if (left <= SHORT_MAX) begin
                        add_word(OP_SHORT | 8'(left - WAIT_W'(1)), '0, LEN_NONE);
                        left = '0;
                    end else begin
                        part = (left < WAIT16_MAX) ? left : WAIT16_MAX;
                        add_word(OP_WAIT16, part, LEN_16);
                        left = left - part;
                    end
                end
            end
            owed_cmds[owed_cmds.size() - 1].is_last = 1'b1;
        endfunction

        // Compare one emitted word against the oldest owed word.
        task check_cmd(input t_cmd_word got);
            t_cmd_word exp;
            if (owed_cmds.size() == 0) begin
                report($sformatf("unexpected word cmd=%02h arg=%0d len=%0d last=%0b",
                                 got.cmd, got.arg, got.len, got.is_last));
            end else begin
                exp = owed_cmds.pop_front();
                if (got.cmd !== exp.cmd)
                    report($sformatf("cmd_byte %02h, want %02h", got.cmd, exp.cmd));
                if (got.arg !== exp.arg)
                    report($sformatf("arg_value %0d, want %0d", got.arg, exp.arg));
                if (got.len !== exp.len)
                    report($sformatf("arg_len %0d, want %0d", got.len, exp.len));
                if (got.is_last !== exp.is_last)
                    report($sformatf("last_cmd %0b, want %0b", got.is_last, exp.is_last));
            end
        endtask
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 14;
    localparam int RAND_WAITS  = 420;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [WAIT_W-1:0] i_wait_samples = '0;
    logic              i_pcm_mode     = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [7:0]        o_cmd_byte;
    logic [WAIT_W-1:0] o_arg_value;
    logic [2:0]        o_arg_len;
    logic              o_last_cmd;

    logic quiet = 1'b0;
    int   cycles = 0;

    cmd_ledger ledger = new();

    wait_command_encoder_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_wait_samples (i_wait_samples),
        .i_pcm_mode     (i_pcm_mode),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cmd_byte     (o_cmd_byte),
        .o_arg_value    (o_arg_value),
        .o_arg_len      (o_arg_len),
        .o_last_cmd     (o_last_cmd)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("wait_command_encoder_top_tb: FAIL");
            $finish;
        end
    end

    // Stall the output at random, except during the quiet stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Watch both channels: note accepted waits, check accepted words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                ledger.note_wait(i_wait_samples, i_pcm_mode);
            if (o_out_valid && !i_out_stall)
                ledger.check_cmd('{o_cmd_byte, o_arg_value, o_arg_len, o_last_cmd});
        end
    end

    // Offer one wait word, with an optional random gap first, and hold it until taken.
    task send_wait(input logic [WAIT_W-1:0] samples, input logic pcm);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_wait_samples <= samples;
        i_pcm_mode     <= pcm;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        logic [WAIT_W-1:0] samples;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero waits, short opcodes, frame shortcuts, 16-bit splits, saturation.
        send_wait('0, 1'b0);
        send_wait('0, 1'b1);
        send_wait(22'd1, 1'b0);
        send_wait(22'd2, 1'b0);
        send_wait(SHORT_MAX, 1'b0);
        send_wait(22'd17, 1'b0);
        send_wait(NTSC_FRAME, 1'b0);
        send_wait(PAL_FRAME, 1'b0);
        send_wait(22'd734, 1'b0);
        send_wait(22'd883, 1'b0);
        send_wait(WAIT16_MAX, 1'b0);
        send_wait(WAIT16_MAX + 22'd1, 1'b0);
        send_wait(WAIT16_MAX + NTSC_FRAME, 1'b0);
        send_wait(WAIT16_MAX + SHORT_MAX, 1'b0);
        send_wait(WAIT_MAX, 1'b0);
        send_wait(WAIT_MAX + 22'd1, 1'b0);
        send_wait('1, 1'b0);
        send_wait(22'd1, 1'b1);
        send_wait(PCM_SHORT, 1'b1);
        send_wait(PCM_SHORT + 22'd1, 1'b1);
        send_wait(NTSC_FRAME, 1'b1);
        send_wait(WAIT_MAX, 1'b1);
        send_wait('1, 1'b1);

        // Random: short waits, frame lengths, long splits and values near or past saturation.
        for (int n = 0; n < RAND_WAITS; n++) begin
            if (n == 150) quiet <= 1'b1;
            if (n == 250) quiet <= 1'b0;
            // Hold off the sender until the encoder has drained.
            if (n == 320) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (ledger.owed_cmds.size() != 0);
                @(posedge i_clk);
            end
            case ($urandom_range(9))
                0, 1, 2: samples = WAIT_W'($urandom_range(20));
                3:       samples = $urandom_range(1) ? NTSC_FRAME : PAL_FRAME;
                4, 5:    samples = WAIT_W'($urandom_range(70000));
                6:       samples = WAIT_W'($urandom_range(300000));
                7:       samples = WAIT_W'($urandom);
                8:       samples = WAIT_MAX - 22'd64 + WAIT_W'($urandom_range(127));
                default: samples = WAIT_W'($urandom_range(1000));
            endcase
            send_wait(samples, 1'($urandom_range(1)));
        end
        i_in_valid <= 1'b0;

        // Drain, then leave time for the load step and a full burst before judging.
        while (ledger.owed_cmds.size() != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);

        if (ledger.owed_cmds.size() != 0)
            ledger.report($sformatf("%0d words never emitted", ledger.owed_cmds.size()));
        if (ledger.mismatches == 0)
            $display("wait_command_encoder_top_tb: PASS");
        else
            $display("wait_command_encoder_top_tb: FAIL");
        $finish;
    end

endmodule
